// File: hdl/wsa_pkg.sv
// Shared types and constants for the windowed statistics block.
// Holds field widths, reset values, register codes, the controller state
// type and the command and status words. No dependencies.
package wsa_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 61;

  localparam int unsigned CPU_W  = 14;
  localparam int unsigned MEM_W  = 40;
  localparam int unsigned IOIN_W = 34;
  localparam int unsigned IO_W   = 36;
  localparam int unsigned STEP_W = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [MEM_W-1:0]  MEM_START_RST = 40'd104857600;
  localparam logic [STEP_W-1:0] MEM_STEP_RST  = 31'd10485760;
  localparam logic [IO_W-1:0]   IO_START_RST  = 36'd1048576;
  localparam logic [STEP_W-1:0] IO_STEP_RST   = 31'd1048576;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_START = 3'd0,
    CFG_MEM_STEP  = 3'd1,
    CFG_IO_START  = 3'd2,
    CFG_IO_STEP   = 3'd3
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic sum_step;
    logic div_start;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_last;
    logic div_busy;
  } status_t;

endpackage

// File: hdl/wsa_div.sv
// Restoring divider, one quotient bit per cycle.
// Gives quotient and remainder; uses no package items.
module wsa_div #(
  parameter int unsigned NW = 46,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o,
  output logic          busy_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dsr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = trial >= {1'b0, dsr_q};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], fits};
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quot_o = quo_q;
  assign rem_o  = rem_q;
  assign busy_o = busy_q;

endmodule

// File: hdl/wsa_ctrl.sv
// Controller for the windowed statistics block.
// Sequences accept, window sum, divide and result; uses wsa_pkg.
module wsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wsa_pkg::status_t status_i,
  output wsa_pkg::cmd_t    cmd_o
);
  import wsa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SUM;
      ST_SUM:       if (status_i.sum_last) state_d = ST_DRAIN;
      ST_DRAIN:     state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (!status_i.div_busy) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_SUM:       cmd_o.sum_step = 1'b1;
      ST_DIV_START: cmd_o.div_start = 1'b1;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/wsa_dp.sv
// Datapath: sample windows, peaks, scales, dividers and result words.
// Uses wsa_pkg and wsa_div.
module wsa_dp #(
  parameter int unsigned WINDOW_DEPTH = wsa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wsa_pkg::cmd_t                   cmd_i,
  output wsa_pkg::status_t                status_o,
  input  logic                            cfg_we_i,
  input  logic [wsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [wsa_pkg::CPU_W-1:0]       cpu_centi_i,
  input  logic [wsa_pkg::MEM_W-1:0]       private_bytes_i,
  input  logic [wsa_pkg::IOIN_W-1:0]      io_read_bytes_i,
  input  logic [wsa_pkg::IOIN_W-1:0]      io_write_bytes_i,
  input  logic [wsa_pkg::IOIN_W-1:0]      io_other_bytes_i,
  output logic [wsa_pkg::CPU_W-1:0]       cpu_average_o,
  output logic [wsa_pkg::CPU_W-1:0]       cpu_peak_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_average_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_peak_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_scale_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_scale_before_o,
  output logic [wsa_pkg::IO_W-1:0]        io_average_o,
  output logic [wsa_pkg::IO_W-1:0]        io_peak_o,
  output logic [wsa_pkg::IO_W-1:0]        io_scale_o,
  output logic [wsa_pkg::IO_W-1:0]        io_scale_before_o
);
  import wsa_pkg::*;

  localparam int unsigned AW     = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW     = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CSUM_W = CPU_W + CW;
  localparam int unsigned MSUM_W = MEM_W + CW;
  localparam int unsigned ISUM_W = IO_W + CW;

  // Window memories.
  logic [CPU_W-1:0] cpu_mem_q [WINDOW_DEPTH];
  logic [MEM_W-1:0] mem_mem_q [WINDOW_DEPTH];
  logic [IO_W-1:0]  io_mem_q  [WINDOW_DEPTH];
  logic [CPU_W-1:0] cpu_rd_q;
  logic [MEM_W-1:0] mem_rd_q;
  logic [IO_W-1:0]  io_rd_q;

  logic [AW-1:0]    slot_q;
  logic [AW-1:0]    rd_idx_q;
  logic [CW-1:0]    held_q;
  logic             rd_pend_q;
  logic [CSUM_W-1:0] cpu_sum_q;
  logic [MSUM_W-1:0] mem_sum_q;
  logic [ISUM_W-1:0] io_sum_q;

  logic [CPU_W-1:0] cpu_high_q;
  logic [MEM_W-1:0] mem_high_q, mem_range_q, mem_old_q;
  logic [IO_W-1:0]  io_high_q, io_range_q, io_old_q;
  logic [STEP_W-1:0] mem_step_q, io_step_q;

  logic [IO_W-1:0]   io_in;
  logic [STEP_W-1:0] mem_step_eff, io_step_eff;
  logic [MEM_W-1:0]  mem_gap;
  logic [IO_W-1:0]   io_gap;
  logic              mem_raise, io_raise;

  logic [CSUM_W-1:0] cpu_quot;
  logic [MSUM_W-1:0] mem_quot;
  logic [ISUM_W-1:0] io_quot;
  logic [CW-1:0]     cpu_rem_nc, mem_rem_nc, io_rem_nc;
  logic [MEM_W-1:0]  mem_gq_nc;
  logic [IO_W-1:0]   io_gq_nc;
  logic [STEP_W-1:0] mem_rem, io_rem;
  logic [4:0]        busy;

  logic [STEP_W-1:0] mem_add, io_add;
  logic [MEM_W:0]    mem_next;
  logic [IO_W:0]     io_next;
  logic [MEM_W-1:0]  mem_range_new, mem_old_new;
  logic [IO_W-1:0]   io_range_new, io_old_new;

  // Summed I/O delta of the incoming word.
  assign io_in = IO_W'(io_read_bytes_i) + IO_W'(io_write_bytes_i)
               + IO_W'(io_other_bytes_i);

  // Window write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cpu_mem_q[slot_q] <= cpu_centi_i;
      mem_mem_q[slot_q] <= private_bytes_i;
      io_mem_q[slot_q]  <= io_in;
    end
  end

  // Window read port, registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_step) begin
      cpu_rd_q <= cpu_mem_q[rd_idx_q];
      mem_rd_q <= mem_mem_q[rd_idx_q];
      io_rd_q  <= io_mem_q[rd_idx_q];
    end
  end

  // Running sums over the held entries.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cpu_sum_q <= '0;
      mem_sum_q <= '0;
      io_sum_q  <= '0;
    end else if (rd_pend_q) begin
      cpu_sum_q <= cpu_sum_q + CSUM_W'(cpu_rd_q);
      mem_sum_q <= mem_sum_q + MSUM_W'(mem_rd_q);
      io_sum_q  <= io_sum_q + ISUM_W'(io_rd_q);
    end
  end

  assign status_o.sum_last = (CW'(rd_idx_q) + CW'(1)) == held_q;
  assign status_o.div_busy = |busy;

  // Slot, fill count and read pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      held_q    <= '0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.sum_step;
      if (cmd_i.accept) begin
        slot_q   <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + AW'(1);
        if (held_q != CW'(WINDOW_DEPTH)) begin
          held_q <= held_q + CW'(1);
        end
        rd_idx_q <= '0;
      end else if (cmd_i.sum_step) begin
        rd_idx_q <= rd_idx_q + AW'(1);
      end
    end
  end

  // Scale raise terms.
  assign mem_step_eff = (mem_step_q == '0) ? STEP_W'(1) : mem_step_q;
  assign io_step_eff  = (io_step_q == '0) ? STEP_W'(1) : io_step_q;
  assign mem_raise    = mem_high_q > mem_range_q;
  assign io_raise     = io_high_q > io_range_q;
  assign mem_gap      = mem_high_q - mem_range_q;
  assign io_gap       = io_high_q - io_range_q;

  // Means and remainders of the gap by the step.
  wsa_div #(.NW(CSUM_W), .DW(CW)) u_cpu_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(cpu_sum_q),
    .divisor_i(held_q), .quot_o(cpu_quot), .rem_o(cpu_rem_nc), .busy_o(busy[0])
  );
  wsa_div #(.NW(MSUM_W), .DW(CW)) u_mem_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(mem_sum_q),
    .divisor_i(held_q), .quot_o(mem_quot), .rem_o(mem_rem_nc), .busy_o(busy[1])
  );
  wsa_div #(.NW(ISUM_W), .DW(CW)) u_io_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(io_sum_q),
    .divisor_i(held_q), .quot_o(io_quot), .rem_o(io_rem_nc), .busy_o(busy[2])
  );
  wsa_div #(.NW(MEM_W), .DW(STEP_W)) u_mem_gap_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(mem_gap),
    .divisor_i(mem_step_eff), .quot_o(mem_gq_nc), .rem_o(mem_rem), .busy_o(busy[3])
  );
  wsa_div #(.NW(IO_W), .DW(STEP_W)) u_io_gap_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(io_gap),
    .divisor_i(io_step_eff), .quot_o(io_gq_nc), .rem_o(io_rem), .busy_o(busy[4])
  );

  // The raised scale is the old scale plus the fewest whole steps that reach the peak, saturating at the field limit.
  always_comb begin
    mem_add  = (mem_rem == '0) ? '0 : mem_step_eff - mem_rem;
    io_add   = (io_rem == '0) ? '0 : io_step_eff - io_rem;
    mem_next = {1'b0, mem_high_q} + (MEM_W + 1)'(mem_add);
    io_next  = {1'b0, io_high_q} + (IO_W + 1)'(io_add);
    mem_range_new = mem_range_q;
    mem_old_new   = mem_old_q;
    io_range_new  = io_range_q;
    io_old_new    = io_old_q;
    if (mem_raise) begin
      mem_old_new   = mem_range_q;
      mem_range_new = mem_next[MEM_W] ? '1 : mem_next[MEM_W-1:0];
    end
    if (io_raise) begin
      io_old_new   = io_range_q;
      io_range_new = io_next[IO_W] ? '1 : io_next[IO_W-1:0];
    end
  end

  // Peaks, scales and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_high_q  <= '0;
      mem_high_q  <= '0;
      io_high_q   <= '0;
      mem_step_q  <= MEM_STEP_RST;
      io_step_q   <= IO_STEP_RST;
      mem_range_q <= MEM_START_RST;
      mem_old_q   <= MEM_START_RST;
      io_range_q  <= IO_START_RST;
      io_old_q    <= IO_START_RST;
    end else begin
      if (cmd_i.accept) begin
        if (cpu_centi_i > cpu_high_q) cpu_high_q <= cpu_centi_i;
        if (private_bytes_i > mem_high_q) mem_high_q <= private_bytes_i;
        if (io_in > io_high_q) io_high_q <= io_in;
      end
      if (cmd_i.finish) begin
        mem_range_q <= mem_range_new;
        mem_old_q   <= mem_old_new;
        io_range_q  <= io_range_new;
        io_old_q    <= io_old_new;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MEM_START: begin
            mem_range_q <= cfg_data_i[MEM_W-1:0];
            mem_old_q   <= cfg_data_i[MEM_W-1:0];
          end
          CFG_MEM_STEP: mem_step_q <= cfg_data_i[STEP_W-1:0];
          CFG_IO_START: begin
            io_range_q <= cfg_data_i[IO_W-1:0];
            io_old_q   <= cfg_data_i[IO_W-1:0];
          end
          CFG_IO_STEP: io_step_q <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result word registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cpu_average_o      <= cpu_quot[CPU_W-1:0];
      cpu_peak_o         <= cpu_high_q;
      mem_average_o      <= mem_quot[MEM_W-1:0];
      mem_peak_o         <= mem_high_q;
      mem_scale_o        <= mem_range_new;
      mem_scale_before_o <= mem_old_new;
      io_average_o       <= io_quot[IO_W-1:0];
      io_peak_o          <= io_high_q;
      io_scale_o         <= io_range_new;
      io_scale_before_o  <= io_old_new;
    end
  end

endmodule

// File: hdl/windowed_stats_autorange.sv
// Windowed statistics with auto-ranging scales. One word at a time: after
// input accept the window is summed one entry per cycle, then the dividers
// run (the widest 46 bits at depth 61) and the result is offered.
// A new word is taken only once the block is idle again.
// Reset (async, active low) clears peaks and fill count and loads defaults.
module windowed_stats_autorange #(
  parameter int unsigned WINDOW_DEPTH = wsa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [wsa_pkg::CPU_W-1:0]       cpu_centi_i,
  input  logic [wsa_pkg::MEM_W-1:0]       private_bytes_i,
  input  logic [wsa_pkg::IOIN_W-1:0]      io_read_bytes_i,
  input  logic [wsa_pkg::IOIN_W-1:0]      io_write_bytes_i,
  input  logic [wsa_pkg::IOIN_W-1:0]      io_other_bytes_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wsa_pkg::CPU_W-1:0]       cpu_average_o,
  output logic [wsa_pkg::CPU_W-1:0]       cpu_peak_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_average_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_peak_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_scale_o,
  output logic [wsa_pkg::MEM_W-1:0]       mem_scale_before_o,
  output logic [wsa_pkg::IO_W-1:0]        io_average_o,
  output logic [wsa_pkg::IO_W-1:0]        io_peak_o,
  output logic [wsa_pkg::IO_W-1:0]        io_scale_o,
  output logic [wsa_pkg::IO_W-1:0]        io_scale_before_o
);
  import wsa_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  wsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  wsa_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .cpu_centi_i, .private_bytes_i, .io_read_bytes_i, .io_write_bytes_i,
    .io_other_bytes_i, .cpu_average_o, .cpu_peak_o, .mem_average_o, .mem_peak_o,
    .mem_scale_o, .mem_scale_before_o, .io_average_o, .io_peak_o, .io_scale_o,
    .io_scale_before_o
  );

endmodule

// File: hdl/wsa_checker.sv
// Port-level checks for the windowed statistics block, bound to the top.
// Depends on wsa_pkg for field widths.
module wsa_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [wsa_pkg::CPU_W-1:0] cpu_average_o,
  input logic [wsa_pkg::CPU_W-1:0] cpu_peak_o,
  input logic [wsa_pkg::MEM_W-1:0] mem_average_o,
  input logic [wsa_pkg::MEM_W-1:0] mem_peak_o,
  input logic [wsa_pkg::MEM_W-1:0] mem_scale_o,
  input logic [wsa_pkg::IO_W-1:0]  io_average_o,
  input logic [wsa_pkg::IO_W-1:0]  io_peak_o,
  input logic [wsa_pkg::IO_W-1:0]  io_scale_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One word at a time: the block is busy right after taking a word.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word taken while busy");

  // A window mean never exceeds the all-time peak.
  a_avg_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cpu_average_o <= cpu_peak_o && mem_average_o <= mem_peak_o
                    && io_average_o <= io_peak_o)
    else $error("average above peak");

  // A scale is never below its peak once raised.
  a_scale_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mem_scale_o >= mem_peak_o && io_scale_o >= io_peak_o)
    else $error("scale below peak");

endmodule

bind windowed_stats_autorange wsa_checker u_wsa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .cpu_average_o, .cpu_peak_o, .mem_average_o, .mem_peak_o, .mem_scale_o,
  .io_average_o, .io_peak_o, .io_scale_o
);

// File: verif/testbench.sv
// Self-checking testbench for windowed_stats_autorange: a queue-fed driver,
// a checking monitor and a built-in predictor of windows, peaks and scales.
// Depends on wsa_pkg and the windowed_stats_autorange RTL.
`timescale 1ns / 1ps

module testbench;
  import wsa_pkg::*;

  localparam int unsigned DEPTH      = WINDOW_DEPTH_DEF;
  localparam int unsigned STALL_MAX  = 5000;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned SETTLE     = 150;
  localparam logic [63:0] MEM_ALL    = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] IO_ALL     = 64'hF_FFFF_FFFF;
  localparam logic [63:0] IOIN_ALL   = 64'h3_FFFF_FFFF;
  localparam logic [63:0] STEP_ALL   = 64'h7FFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

  typedef struct packed {
    logic [CPU_W-1:0]  cpu;
    logic [MEM_W-1:0]  mem;
    logic [IOIN_W-1:0] rd;
    logic [IOIN_W-1:0] wr;
    logic [IOIN_W-1:0] oth;
  } sample_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu_avg;
    logic [CPU_W-1:0] cpu_pk;
    logic [MEM_W-1:0] mem_avg;
    logic [MEM_W-1:0] mem_pk;
    logic [MEM_W-1:0] mem_sc;
    logic [MEM_W-1:0] mem_sc_old;
    logic [IO_W-1:0]  io_avg;
    logic [IO_W-1:0]  io_pk;
    logic [IO_W-1:0]  io_sc;
    logic [IO_W-1:0]  io_sc_old;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CPU_W-1:0]      cpu_centi = '0;
  logic [MEM_W-1:0]      private_bytes = '0;
  logic [IOIN_W-1:0]     io_read_bytes = '0;
  logic [IOIN_W-1:0]     io_write_bytes = '0;
  logic [IOIN_W-1:0]     io_other_bytes = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  stats_t                got;

  windowed_stats_autorange dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .cpu_centi_i        (cpu_centi),
    .private_bytes_i    (private_bytes),
    .io_read_bytes_i    (io_read_bytes),
    .io_write_bytes_i   (io_write_bytes),
    .io_other_bytes_i   (io_other_bytes),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .cpu_average_o      (got.cpu_avg),
    .cpu_peak_o         (got.cpu_pk),
    .mem_average_o      (got.mem_avg),
    .mem_peak_o         (got.mem_pk),
    .mem_scale_o        (got.mem_sc),
    .mem_scale_before_o (got.mem_sc_old),
    .io_average_o       (got.io_avg),
    .io_peak_o          (got.io_pk),
    .io_scale_o         (got.io_sc),
    .io_scale_before_o  (got.io_sc_old)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: configuration, windows, peaks and scales.
  logic [63:0] mem_start, mem_step, io_start, io_step;
  logic [63:0] cpu_win [DEPTH];
  logic [63:0] mem_win [DEPTH];
  logic [63:0] io_win  [DEPTH];
  int unsigned slot, held;
  logic [63:0] cpu_hi, mem_hi, io_hi;
  logic [63:0] mem_rng, mem_rng_old, io_rng, io_rng_old;

  sample_t sample_q [$];
  stats_t  stats_q [$];

  int  errors = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  hold_req = 0;
  int  watchdog = 0;
  bit  timed_out = 1'b0;

  // Range rise toward the peak in whole steps, saturating at the field limit.
  task automatic raise_range(input logic [63:0] peak, inout logic [63:0] rng,
                             inout logic [63:0] old, input logic [63:0] step,
                             input logic [63:0] limit);
    logic [63:0] inc, k, nxt;
    if (peak > rng) begin
      old = rng;
      inc = (step == 0) ? 64'd1 : step;
      k = (peak - rng + inc - 1) / inc;
      nxt = rng + k * inc;
      rng = (nxt > limit) ? limit : nxt;
    end
  endtask

  function automatic logic [63:0] window_avg(input logic [63:0] win [DEPTH],
                                             input int unsigned n);
    logic [63:0] sum;
    sum = 0;
    for (int i = 0; i < n; i++) sum += win[i];
    return (n == 0) ? 64'd0 : sum / n;
  endfunction

  // Update the predicted state with one sample word and queue its statistics.
  task automatic predict_stats(input sample_t s);
    logic [63:0] io_sum;
    stats_t e;
    io_sum = 64'(s.rd) + 64'(s.wr) + 64'(s.oth);
    cpu_win[slot] = 64'(s.cpu);
    mem_win[slot] = 64'(s.mem);
    io_win[slot]  = io_sum & IO_ALL;
    slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
    if (held < DEPTH) held++;
    if (64'(s.cpu) > cpu_hi) cpu_hi = 64'(s.cpu);
    if (64'(s.mem) > mem_hi) mem_hi = 64'(s.mem);
    if (io_sum > io_hi) io_hi = io_sum;
    raise_range(mem_hi, mem_rng, mem_rng_old, mem_step, MEM_ALL);
    raise_range(io_hi, io_rng, io_rng_old, io_step, IO_ALL);
    e.cpu_avg    = CPU_W'(window_avg(cpu_win, held));
    e.cpu_pk     = CPU_W'(cpu_hi);
    e.mem_avg    = MEM_W'(window_avg(mem_win, held));
    e.mem_pk     = MEM_W'(mem_hi);
    e.mem_sc     = MEM_W'(mem_rng);
    e.mem_sc_old = MEM_W'(mem_rng_old);
    e.io_avg     = IO_W'(window_avg(io_win, held));
    e.io_pk      = IO_W'(io_hi);
    e.io_sc      = IO_W'(io_rng);
    e.io_sc_old  = IO_W'(io_rng_old);
    stats_q.push_back(e);
  endtask

  // Register write effects on the predicted configuration.
  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    case (idx)
      CFG_MEM_START: begin
        mem_start = val & MEM_ALL;
        mem_rng = mem_start;
        mem_rng_old = mem_start;
      end
      CFG_MEM_STEP: begin
        mem_step = val & STEP_ALL;
      end
      CFG_IO_START: begin
        io_start = val & IO_ALL;
        io_rng = io_start;
        io_rng_old = io_start;
      end
      CFG_IO_STEP: begin
        io_step = val & STEP_ALL;
      end
      default: begin
      end
    endcase
  endtask

  // Input driver: pops sample words from the queue with random gaps.
  int unsigned send_gap = 0;
  always @(posedge clk or negedge rst_n) begin
    logic nv;
    sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_stats({cpu_centi, private_bytes, io_read_bytes, io_write_bytes,
                       io_other_bytes});
        nv = 1'b0;
        send_gap = send_idle ? $urandom_range(0, 14) : 0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_q.size() > 0) begin
          s = sample_q.pop_front();
          cpu_centi      <= s.cpu;
          private_bytes  <= s.mem;
          io_read_bytes  <= s.rd;
          io_write_bytes <= s.wr;
          io_other_bytes <= s.oth;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // Result monitor: random stalls, one long hold on request, field checks.
  int unsigned recv_stall = 0;
  int unsigned hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk or negedge rst_n) begin
    stats_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result word: %p", got);
        end else begin
          e = stats_q.pop_front();
          if (e !== got) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %p, got %p", e, got);
          end
        end
        recv_stall = recv_idle ? $urandom_range(0, 14) : 0;
      end
      if (hold_req != hold_seen) begin
        hold_seen++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) hold_left--;
      else if (recv_stall > 0) recv_stall--;
      out_ready <= (hold_left == 0) && (recv_stall == 0);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      watchdog = 0;
    else
      watchdog++;
    if (watchdog >= STALL_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_q.size() > 0 || in_valid || stats_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random magnitude: mostly small to medium so scales climb in steps.
  function automatic logic [63:0] rand_mag(input logic [63:0] all);
    case ($urandom_range(0, 15))
      0: return all;
      1, 2: return rand64() & all;
      3: return 0;
      default: return rand64() & ((64'd1 << $urandom_range(8, 30)) - 1) & all;
    endcase
  endfunction

  task automatic add_random(input int n);
    sample_t s;
    repeat (n) begin
      s.cpu = ($urandom_range(0, 9) == 0) ? CPU_W'($urandom) :
              CPU_W'($urandom_range(0, 10000));
      s.mem = MEM_W'(rand_mag(MEM_ALL));
      s.rd  = IOIN_W'(rand_mag(IOIN_ALL));
      s.wr  = IOIN_W'(rand_mag(IOIN_ALL));
      s.oth = IOIN_W'(rand_mag(IOIN_ALL));
      sample_q.push_back(s);
    end
  endtask

  task automatic add_sample(input logic [63:0] c, m, r, w, o);
    sample_t s;
    s = {CPU_W'(c), MEM_W'(m), IOIN_W'(r), IOIN_W'(w), IOIN_W'(o)};
    sample_q.push_back(s);
  endtask

  initial begin
    mem_start = 64'(MEM_START_RST);
    mem_step  = 64'(MEM_STEP_RST);
    io_start  = 64'(IO_START_RST);
    io_step   = 64'(IO_STEP_RST);
    slot = 0;
    held = 0;
    cpu_hi = 0;
    mem_hi = 0;
    io_hi = 0;
    mem_rng = mem_start;
    mem_rng_old = mem_start;
    io_rng = io_start;
    io_rng_old = io_start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at reset defaults: zeros, scale edges, CPU above range.
    add_sample(0, 0, 0, 0, 0);
    add_sample(1, 64'd104857600, 1, 0, 0);
    add_sample(10000, 64'd104857601, 64'd1048576, 1, 0);
    add_sample(10001, 64'd209715200, 64'd5000000, 64'd5000000, 64'd5000000);
    add_sample(64'h3FFF, 64'h55_5555_5555, 64'h1_5555_5555, 64'h2_AAAA_AAAA, 0);
    add_sample(64'h2AAA, 64'hAA_AAAA_AAAA, 64'h2_AAAA_AAAA, 64'h1_5555_5555, 64'h3_0000_0000);
    add_sample(0, 64'd12345, 0, 0, 64'd7);
    wait_idle();

    // Small starts and steps; the maxima in one word raise both scales to the peaks, the memory scale to its limit.
    cfg_write(CFG_MEM_START, 1);
    cfg_write(CFG_MEM_STEP, 1);
    cfg_write(CFG_IO_START, 1);
    cfg_write(CFG_IO_STEP, 1);
    add_sample(5, 64'd1000, 64'd3, 64'd4, 64'd5);
    add_sample(64'h3FFF, MEM_ALL, IOIN_ALL, IOIN_ALL, IOIN_ALL);
    add_sample(0, 0, 0, 0, 0);
    add_random(60);
    wait_idle();

    // Largest start values and I/O step, a 2^30 memory step; steps of zero later.
    cfg_write(CFG_MEM_START, MEM_ALL);
    cfg_write(CFG_IO_START, IO_ALL);
    cfg_write(CFG_MEM_STEP, 64'd1073741824);
    cfg_write(CFG_IO_STEP, STEP_ALL);
    cfg_write(CFG_UNUSED, rand64());
    hold_req++;
    send_idle = 1'b0;
    add_random(80);
    wait_idle();
    send_idle = 1'b1;

    // Step registers of zero act as one; starts of zero and raw 40-bit data.
    cfg_write(CFG_MEM_STEP, 0);
    cfg_write(CFG_IO_STEP, 64'hFF_8000_0000);
    cfg_write(CFG_MEM_START, 0);
    cfg_write(CFG_IO_START, 64'hFF_0000_0010);
    add_random(90);
    wait_idle();

    // Mid-range settings with no idling on either side, then random again.
    cfg_write(CFG_MEM_START, 64'd104857600);
    cfg_write(CFG_MEM_STEP, 64'd10485760);
    cfg_write(CFG_IO_START, 64'd1048576);
    cfg_write(CFG_IO_STEP, 64'd1048576);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    add_random(50);
    wait_idle();
    send_idle = 1'b1;
    recv_idle = 1'b1;

    cfg_write(CFG_MEM_START, rand64() & MEM_ALL);
    cfg_write(CFG_MEM_STEP, $urandom_range(1, 1 << 20));
    cfg_write(CFG_IO_START, rand64() & 64'hFFFFFFF);
    cfg_write(CFG_IO_STEP, $urandom_range(1, 1 << 16));
    add_random(110);
    wait_idle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/wsa_pkg.sv
hdl/wsa_div.sv
hdl/wsa_ctrl.sv
hdl/wsa_dp.sv
hdl/windowed_stats_autorange.sv
hdl/wsa_checker.sv
verif/testbench.sv
